### hw/rtl/dpsq_pkg.sv
package dpsq_pkg;

    localparam int DEPTH       = 64;
    localparam int PRIO_BITS   = 16;
    localparam int ID_BITS     = 32;
    localparam int KIND_BITS   = 2;
    localparam int STATUS_BITS = 2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ARRIVE  = 2'd0,
        KIND_OLDEST  = 2'd1,
        KIND_HIGHEST = 2'd2
    } t_kind;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic                 valid;
        logic [PRIO_BITS-1:0] prio;
        logic [ID_BITS-1:0]   id;
    } t_slot;

    typedef struct packed {
        logic                 start;
        logic                 rec;
        logic                 shift;
        logic                 shift_all;
        logic                 load;
        logic [PRIO_BITS-1:0] load_prio;
        logic [ID_BITS-1:0]   load_id;
    } t_cell_ctl;

endpackage

### hw/rtl/dpsq_if.sv
interface dpsq_req_if;
    import dpsq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_BITS-1:0] kind;
    logic [PRIO_BITS-1:0] priority_req;

    modport source (output valid, output kind, output priority_req, input ready);
    modport sink   (input valid, input kind, input priority_req, output ready);
endinterface

interface dpsq_rsp_if;
    import dpsq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ID_BITS-1:0]     customer_id;
    logic [STATUS_BITS-1:0] status;

    modport source (output valid, output customer_id, output status, input ready);
    modport sink   (input valid, input customer_id, input status, output ready);
endinterface

### hw/rtl/dpsq_cell.sv
module dpsq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dpsq_pkg::t_cell_ctl i_ctl,
    input  logic              i_prev_valid,
    input  logic              i_wave_in,
    input  dpsq_pkg::t_slot   i_next,
    output dpsq_pkg::t_slot   o_slot,
    output logic              o_wave
);
    import dpsq_pkg::*;

    logic                 r_valid;
    logic [PRIO_BITS-1:0] r_prio;
    logic [ID_BITS-1:0]   r_id;
    logic                 r_wave;
    logic                 r_geq;
    logic                 w_shift_take;
    logic                 w_load_take;

    assign w_shift_take = i_ctl.shift && (i_ctl.shift_all || r_geq);
    assign w_load_take  = i_ctl.load && !r_valid && i_prev_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_wave  <= 1'b0;
            r_geq   <= 1'b0;
        end else begin
            r_wave <= i_wave_in;
            if (i_ctl.start) begin
                r_geq <= 1'b0;
            end else if (r_wave) begin
                r_geq <= 1'b1;
            end else if (i_ctl.rec) begin
                r_geq <= 1'b0;
            end
            if (w_shift_take) begin
                r_valid <= i_next.valid;
            end else if (w_load_take) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift_take) begin
            r_prio <= i_next.prio;
            r_id   <= i_next.id;
        end else if (w_load_take) begin
            r_prio <= i_ctl.load_prio;
            r_id   <= i_ctl.load_id;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.prio  = r_prio;
    assign o_slot.id    = r_id;
    assign o_wave       = r_wave;

endmodule

### hw/rtl/dual_policy_service_queue_core.sv
// channel  | dir | handshake     | word
// i_req    | in  | valid / ready | kind, priority_req
// o_rsp    | out | valid / ready | customer_id, status
//
// Arrival, serve-oldest, empty/full rejects and unused kinds are each answered
// in the cycle after acceptance. Serve-highest: a one-hot scan token walks the
// cell row, one cell a cycle, then the row compacts once the output is free.
// Reset clears the row, the id counter and the response valid flag; no clearing pass.
// A held response blocks new words only while it stalls at the output.
module dual_policy_service_queue_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpsq_req_if.sink   i_req,
    dpsq_rsp_if.source o_rsp
);
    import dpsq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_SHIFT = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [ID_BITS-1:0]   r_last_id, n_last_id;
    logic [PRIO_BITS-1:0] r_best, n_best;
    logic [ID_BITS-1:0]   r_best_id, n_best_id;
    logic                 r_have, n_have;
    logic                 r_out_v, n_out_v;
    logic [ID_BITS-1:0]   r_out_id, n_out_id;
    t_status              r_out_status, n_out_status;

    t_cell_ctl            w_ctl;
    t_slot                w_slot [DEPTH];
    logic                 w_wave [DEPTH];
    logic                 w_sel_valid;
    logic [PRIO_BITS-1:0] w_sel_prio;
    logic [ID_BITS-1:0]   w_sel_id;
    logic                 w_out_free;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                dpsq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (w_ctl),
                    .i_prev_valid (1'b1),
                    .i_wave_in    (w_ctl.start),
                    .i_next       (w_slot[g+1]),
                    .o_slot       (w_slot[g]),
                    .o_wave       (w_wave[g])
                );
            end else if (g == DEPTH - 1) begin : g_tail
                dpsq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (w_ctl),
                    .i_prev_valid (w_slot[g-1].valid),
                    .i_wave_in    (w_wave[g-1]),
                    .i_next       ('0),
                    .o_slot       (w_slot[g]),
                    .o_wave       (w_wave[g])
                );
            end else begin : g_mid
                dpsq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (w_ctl),
                    .i_prev_valid (w_slot[g-1].valid),
                    .i_wave_in    (w_wave[g-1]),
                    .i_next       (w_slot[g+1]),
                    .o_slot       (w_slot[g]),
                    .o_wave       (w_wave[g])
                );
            end
        end
    endgenerate

    always_comb begin
        w_sel_valid = 1'b0;
        w_sel_prio  = '0;
        w_sel_id    = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_wave[k]) begin
                w_sel_valid = w_sel_valid | w_slot[k].valid;
                w_sel_prio  = w_sel_prio | w_slot[k].prio;
                w_sel_id    = w_sel_id | w_slot[k].id;
            end
        end
    end

    assign w_full      = w_slot[DEPTH-1].valid;
    assign w_empty     = !w_slot[0].valid;
    assign w_out_free  = !r_out_v || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        n_state      = r_state;
        n_last_id    = r_last_id;
        n_best       = r_best;
        n_best_id    = r_best_id;
        n_have       = r_have;
        n_out_v      = r_out_v && !o_rsp.ready;
        n_out_id     = r_out_id;
        n_out_status = r_out_status;
        w_ctl        = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_v      = 1'b1;
                    n_out_id     = '0;
                    n_out_status = STAT_OK;
                    case (t_kind'(i_req.kind))
                        KIND_ARRIVE: begin
                            if (w_full) begin
                                n_out_status = STAT_FULL;
                            end else begin
                                n_last_id       = r_last_id + 1'b1;
                                w_ctl.load      = 1'b1;
                                w_ctl.load_prio = i_req.priority_req;
                                w_ctl.load_id   = n_last_id;
                                n_out_id        = n_last_id;
                            end
                        end
                        KIND_OLDEST: begin
                            if (w_empty) begin
                                n_out_status = STAT_EMPTY;
                            end else begin
                                w_ctl.shift     = 1'b1;
                                w_ctl.shift_all = 1'b1;
                                n_out_id        = w_slot[0].id;
                            end
                        end
                        KIND_HIGHEST: begin
                            if (w_empty) begin
                                n_out_status = STAT_EMPTY;
                            end else begin
                                n_out_v     = 1'b0;
                                w_ctl.start = 1'b1;
                                n_have      = 1'b0;
                                n_state     = ST_SCAN;
                            end
                        end
                        default: begin
                            n_out_status = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                w_ctl.rec = w_sel_valid && (!r_have || (w_sel_prio > r_best));
                if (w_ctl.rec) begin
                    n_best    = w_sel_prio;
                    n_best_id = w_sel_id;
                    n_have    = 1'b1;
                end
                if (w_wave[DEPTH-1]) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (w_out_free) begin
                    w_ctl.shift  = 1'b1;
                    n_out_v      = 1'b1;
                    n_out_id     = r_best_id;
                    n_out_status = STAT_OK;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_last_id <= '0;
            r_have    <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_last_id <= n_last_id;
            r_have    <= n_have;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best       <= n_best;
        r_best_id    <= n_best_id;
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
    end

    assign o_rsp.valid       = r_out_v;
    assign o_rsp.customer_id = r_out_id;
    assign o_rsp.status      = r_out_status;

endmodule

### hw/rtl/dpsq_checker.sv
module dpsq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_req_valid,
    input logic                             i_req_ready,
    input logic [dpsq_pkg::KIND_BITS-1:0]   i_req_kind,
    input logic                             i_rsp_valid,
    input logic                             i_rsp_ready,
    input logic [dpsq_pkg::ID_BITS-1:0]     i_rsp_id,
    input logic [dpsq_pkg::STATUS_BITS-1:0] i_rsp_status
);
    import dpsq_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_id)))
        else $error("stalled response word changed");

    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |-> !(i_req_valid && i_req_ready))
        else $error("request taken while response stalls");

    a_reject_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != STAT_OK)) |-> (i_rsp_id == '0))
        else $error("rejected word carries an id");

    a_fast_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_kind != KIND_HIGHEST)) |=> i_rsp_valid)
        else $error("single-cycle request gave no response");

endmodule

bind dual_policy_service_queue_core dpsq_checker u_dpsq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_kind   (i_req.kind),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_id     (o_rsp.customer_id),
    .i_rsp_status (o_rsp.status)
);

### test/dpsq_checker.sv
`timescale 1ns / 1ps

module dpsq_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    dpsq_req_if  i_req,
    dpsq_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_full_count,
    output int   o_empty_count,
    output int   o_peak_fill
);
    import dpsq_pkg::*;

    typedef struct packed {
        logic [PRIO_BITS-1:0] prio;
        logic [ID_BITS-1:0]   id;
    } t_waiting;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        t_status            status;
    } t_service;

    t_waiting           waiting_line[$];
    t_service           owed_services[$];
    logic [ID_BITS-1:0] last_id;

    function automatic t_service apply_word(logic [KIND_BITS-1:0] kind,
                                            logic [PRIO_BITS-1:0] prio);
        t_service res;
        t_waiting entry;
        int       best;
        res.id     = '0;
        res.status = STAT_OK;
        best       = 0;
        case (kind)
            KIND_ARRIVE: begin
                if (waiting_line.size() >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    last_id      = last_id + 1'b1;
                    entry.prio   = prio;
                    entry.id     = last_id;
                    waiting_line = {waiting_line, entry};
                    res.id       = last_id;
                end
            end
            KIND_OLDEST: begin
                if (waiting_line.size() == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    entry  = waiting_line.pop_front();
                    res.id = entry.id;
                end
            end
            KIND_HIGHEST: begin
                if (waiting_line.size() == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    // strict compare keeps the earliest arrival on a tie
                    for (int k = 1; k < waiting_line.size(); k++) begin
                        if (waiting_line[k].prio > waiting_line[best].prio) begin
                            best = k;
                        end
                    end
                    res.id = waiting_line[best].id;
                    waiting_line.delete(best);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic note_mismatch(string what, logic [ID_BITS-1:0] want,
                                 logic [ID_BITS-1:0] got);
        o_fail_count = o_fail_count + 1;
        if (o_fail_count <= 10) begin
            $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_full_count  = 0;
        o_empty_count = 0;
        o_peak_fill   = 0;
        last_id       = '0;
    end

    always @(posedge i_clk) begin
        t_service want;
        t_service got;
        if (!i_rst_n) begin
            waiting_line.delete();
            owed_services.delete();
            last_id = '0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (owed_services.size() == 0) begin
                    note_mismatch("unexpected word, id", '0, i_rsp.customer_id);
                end else begin
                    want = owed_services.pop_front();
                    if (i_rsp.customer_id !== want.id) begin
                        note_mismatch("customer_id", want.id, i_rsp.customer_id);
                    end
                    if (i_rsp.status !== want.status) begin
                        note_mismatch("status", ID_BITS'(want.status),
                                      ID_BITS'(i_rsp.status));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                got = apply_word(i_req.kind, i_req.priority_req);
                if (got.status == STAT_FULL) begin
                    o_full_count = o_full_count + 1;
                end
                if (got.status == STAT_EMPTY) begin
                    o_empty_count = o_empty_count + 1;
                end
                if (waiting_line.size() > o_peak_fill) begin
                    o_peak_fill = waiting_line.size();
                end
                owed_services = {owed_services, got};
            end
        end
        o_pending = owed_services.size();
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dpsq_pkg::*;

    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
    localparam int WORD_TARGET    = 650;
    localparam int TIDE_LEN       = 110;
    localparam int STALL_LEN      = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    logic i_clk;
    logic i_rst_n;

    dpsq_req_if req_ch();
    dpsq_rsp_if rsp_ch();

    int fail_count;
    int pending;
    int full_count;
    int empty_count;
    int peak_fill;
    int send_idle_pct;
    int recv_idle_pct;
    int words_sent;
    bit hold_request;

    dual_policy_service_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    dpsq_scoreboard u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_full_count  (full_count),
        .o_empty_count (empty_count),
        .o_peak_fill   (peak_fill)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic send_word(input logic [KIND_BITS-1:0] kind,
                             input logic [PRIO_BITS-1:0] prio);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= kind;
        req_ch.priority_req <= prio;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    function automatic logic [KIND_BITS-1:0] pick_kind(bit filling);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3) return KIND_UNUSED;
        if (roll < (filling ? 93 : 18)) return KIND_ARRIVE;
        return $urandom_range(1) ? KIND_OLDEST : KIND_HIGHEST;
    endfunction

    function automatic logic [PRIO_BITS-1:0] pick_prio();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40) return PRIO_BITS'($urandom_range(3));
        if (roll < 55) return $urandom_range(1) ? '1 : '0;
        if (roll < 65) return PRIO_BITS'(1) << $urandom_range(PRIO_BITS - 1);
        return PRIO_BITS'($urandom);
    endfunction

    // receiver: random backpressure, plus one long hold-off on request
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (STALL_LEN) @(negedge i_clk);
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int                   real_words;
        logic [KIND_BITS-1:0] kind;
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_ARRIVE;
        req_ch.priority_req = '0;
        send_idle_pct       = 34;
        recv_idle_pct       = 74;
        hold_request        = 1'b0;
        words_sent          = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(KIND_OLDEST,  16'hFFFF);
        send_word(KIND_HIGHEST, 16'h0000);
        send_word(KIND_UNUSED,  16'h1234);
        send_word(KIND_ARRIVE,  16'h0000);
        send_word(KIND_ARRIVE,  16'hFFFF);
        send_word(KIND_ARRIVE,  16'hFFFF);
        send_word(KIND_ARRIVE,  16'h8000);
        send_word(KIND_ARRIVE,  16'h0001);
        send_word(KIND_ARRIVE,  16'h5555);
        send_word(KIND_ARRIVE,  16'hAAAA);
        send_word(KIND_HIGHEST, 16'h0000);
        send_word(KIND_HIGHEST, 16'hFFFF);
        send_word(KIND_OLDEST,  16'h0000);
        send_word(KIND_UNUSED,  16'hFFFF);
        send_word(KIND_HIGHEST, 16'h0000);
        send_word(KIND_ARRIVE,  16'hAAAA);
        send_word(KIND_HIGHEST, 16'h5555);
        send_word(KIND_OLDEST,  16'h0000);
        send_word(KIND_HIGHEST, 16'h0000);
        send_word(KIND_HIGHEST, 16'h0000);
        send_word(KIND_HIGHEST, 16'h0000);
        send_word(KIND_OLDEST,  16'h0000);

        // fill toward full, then drain toward empty, in each idle pattern
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 74 : 0;
            recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 34 : 0;
            if (phase == 2) hold_request = 1'b1;
            real_words = 0;
            while (real_words < WORD_TARGET / 3 + 1) begin
                kind = pick_kind(((real_words / TIDE_LEN) % 2) == 0);
                send_word(kind, pick_prio());
                if (kind != KIND_UNUSED) real_words++;
            end
        end

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DEPTH + 8) @(negedge i_clk);

        $display("Run: %0d words through fill/drain cycles, %0d full rejects, %0d empty serves",
                 words_sent, full_count, empty_count);
        $display("Peak occupancy %0d of %0d, %0d mismatches", peak_fill, DEPTH, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
